// ----- sv/circular_position_list_defines.svh -----
// Assertion macros used by the checker file of the circular position list.
`ifndef CIRCULAR_POSITION_LIST_DEFINES_SVH
`define CIRCULAR_POSITION_LIST_DEFINES_SVH

// Concurrent assertion on clk, switched off while rst is high.
`define CPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk that also holds across reset.
`define CPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cpl_pkg.sv -----
package cpl_pkg;

  localparam int POS_W       = 16;
  localparam int VAL_W       = 8;
  localparam int NSIDE_W     = 7;
  localparam int OPC_W       = 2;
  localparam int ST_W        = 2;
  localparam int CNT_OUT_W   = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_POLYGON = 2'd2,
    OP_DUMP    = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_START,
    S_INS_DIV,
    S_INS_CHK,
    S_INS_MOV,
    S_DEL_START,
    S_DEL_DIV,
    S_DEL_CHK,
    S_DEL_MOV,
    S_DUMP_RD,
    S_DUMP_LD,
    S_FINISH
  } state_t;

endpackage

// ----- sv/cpl_ram.sv -----
module cpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cpl_mod.sv -----
module cpl_mod #(
  parameter int RW = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [cpl_pkg::POS_W-1:0] dividend,
  input  logic [RW:0]              divisor,
  output logic                     done,
  output logic [RW-1:0]            remainder
);
  import cpl_pkg::*;

  // Restoring remainder, one dividend bit per cycle.
  localparam int SW = $clog2(POS_W + 1);

  logic              busy;
  logic [SW-1:0]     step;
  logic [POS_W-1:0]  shreg;
  logic [RW:0]       dvs;
  logic [RW:0]       trial;
  logic [RW-1:0]     rem_next;

  assign trial    = {remainder, shreg[POS_W-1]};
  assign rem_next = (trial >= dvs) ? RW'(trial - dvs) : RW'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy      <= 1'b1;
        step      <= SW'(POS_W);
        shreg     <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        remainder <= rem_next;
        shreg     <= {shreg[POS_W-2:0], 1'b0};
        step      <= step - SW'(1);
        if (step == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/circular_position_list.sv -----
// Circular position list: an ordered list of up to DEPTH eight-bit vertex values
// kept in list order in a single-port-read entry memory, plus an entry count.
// Each input transaction carries an opcode in s_tuser: insert places the value
// directly after the entry at position mod count (into an empty list it becomes
// the only entry), delete removes the entry at position mod count, add polygon
// runs polygon_size-2 inserts of the value 1 at the same position, and dump
// returns every entry in order, one output transaction each, with tlast on the
// final one. Other opcodes and an empty dump return exactly one transaction with
// tlast set, carrying the status (ok, empty, or full with the insert dropped)
// and the count after the operation. Timing: one item is processed at a time
// and s_tready is low while it runs. An insert into a non-empty, non-full list
// and a delete both first reduce the position by the count in the shared
// bit-serial remainder unit, one step per position bit, and then move each
// entry that has to move through the entry memory's registered read port, a
// read state followed by a write state. A dump likewise reads each entry and
// then loads it into the output register, and waits there while the output is
// stalled. The entry memory needs no clearing after reset, since only entries
// below the count are ever read. An output transaction is held in a register,
// so the next input transaction can be taken while it waits.
module circular_position_list #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [15:0] position, [23:16] value, [30:24] polygon_size, [31] zero
  input  logic [cpl_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] opcode
  input  logic [cpl_pkg::OPC_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [8:2] count, [16:9] entry_value, [23:17] zero
  output logic [cpl_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);
  import cpl_pkg::*;

  // Address width, count width and a width that holds DEPTH plus one step.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 1;

  state_t state, state_next;

  // Item registers and the list count.
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      p;
  logic [POS_W-1:0]   pos;
  logic [VAL_W-1:0]   ins_val;
  logic [NSIDE_W-1:0] left;
  status_t            st;

  // Output register.
  status_t              out_status;
  logic [CNT_OUT_W-1:0] out_count;
  logic [VAL_W-1:0]     out_val;

  // Memory and remainder unit hookup.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [AW-1:0]    div_rem;
  logic             out_load;

  opcode_t            in_op;
  logic [POS_W-1:0]   in_pos;
  logic [VAL_W-1:0]   in_val;
  logic [NSIDE_W-1:0] in_nside;

  logic out_free;
  logic list_full;
  logic list_empty;
  logic ins_more;
  logic del_more;
  logic dump_last;

  assign in_op    = opcode_t'(s_tuser);
  assign in_pos   = s_tdata[POS_W-1:0];
  assign in_val   = s_tdata[POS_W+VAL_W-1:POS_W];
  assign in_nside = s_tdata[POS_W+VAL_W+NSIDE_W-1:POS_W+VAL_W];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign list_full  = XW'(cnt) >= XW'(DEPTH);
  assign list_empty = (cnt == '0);
  // Insert shifts entries up from the tail until the slot after p is open.
  assign ins_more   = XW'(idx) > (XW'(p) + XW'(1));
  // Delete pulls entries down from just after p to the tail.
  assign del_more   = (XW'(idx) + XW'(1)) < XW'(cnt);
  assign dump_last  = (XW'(idx) + XW'(1)) == XW'(cnt);

  assign m_tdata = {{(OUT_TDATA_W - ST_W - CNT_OUT_W - VAL_W){1'b0}},
                    out_val, out_count, out_status};

  cpl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpl_mod #(
    .RW (AW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pos),
    .divisor   (XW'(cnt)),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_op)
            OP_INSERT:  state_next = S_INS_START;
            OP_DELETE:  state_next = list_empty ? S_FINISH : S_DEL_START;
            OP_POLYGON: state_next = (in_nside >= NSIDE_W'(3)) ? S_INS_START : S_FINISH;
            OP_DUMP:    state_next = list_empty ? S_FINISH : S_DUMP_RD;
          endcase
        end
      end
      S_INS_START: begin
        if (left == '0) begin
          state_next = S_FINISH;
        end else if (!list_full && !list_empty) begin
          state_next = S_INS_DIV;
        end
      end
      S_INS_DIV:   if (div_done) state_next = S_INS_CHK;
      S_INS_CHK:   state_next = ins_more ? S_INS_MOV : S_INS_START;
      S_INS_MOV:   state_next = S_INS_CHK;
      S_DEL_START: state_next = S_DEL_DIV;
      S_DEL_DIV:   if (div_done) state_next = S_DEL_CHK;
      S_DEL_CHK:   state_next = del_more ? S_DEL_MOV : S_FINISH;
      S_DEL_MOV:   state_next = S_DEL_CHK;
      S_DUMP_RD:   state_next = S_DUMP_LD;
      S_DUMP_LD: begin
        if (out_free) begin
          state_next = dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory, remainder unit and output register controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ins_val;
    ram_raddr = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_INS_START: begin
        if (left != '0 && !list_full) begin
          if (list_empty) begin
            ram_we = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_INS_CHK: begin
        if (ins_more) begin
          ram_raddr = idx - AW'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = p + AW'(1);
        end
      end
      S_INS_MOV, S_DEL_MOV: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      S_DEL_START: div_start = 1'b1;
      S_DEL_CHK:   ram_raddr = idx + AW'(1);
      S_DUMP_RD:   ram_raddr = idx;
      S_DUMP_LD: begin
        ram_raddr = idx;
        out_load  = out_free;
      end
      S_FINISH:    out_load = out_free;
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end
      unique case (state)
        S_INS_START: begin
          if (left != '0 && !list_full && list_empty) begin
            cnt <= CW'(1);
          end
        end
        S_INS_CHK: if (!ins_more) cnt <= cnt + CW'(1);
        S_DEL_CHK: if (!del_more) cnt <= cnt - CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          pos     <= in_pos;
          ins_val <= in_val;
          idx     <= '0;
          st      <= ST_OK;
          if (list_empty && (in_op == OP_DELETE || in_op == OP_DUMP)) begin
            st <= ST_EMPTY;
          end
          if (in_op == OP_INSERT) begin
            left <= NSIDE_W'(1);
          end else if (in_nside >= NSIDE_W'(3)) begin
            left <= in_nside - NSIDE_W'(2);
          end else begin
            left <= '0;
          end
          if (in_op == OP_POLYGON) begin
            ins_val <= VAL_W'(1);
          end
        end
      end
      S_INS_START: begin
        if (left != '0) begin
          if (list_full) begin
            st   <= ST_FULL;
            left <= left - NSIDE_W'(1);
          end else if (list_empty) begin
            left <= left - NSIDE_W'(1);
          end
        end
      end
      S_INS_DIV: begin
        if (div_done) begin
          p   <= div_rem;
          idx <= AW'(cnt);
        end
      end
      S_INS_CHK: if (!ins_more) left <= left - NSIDE_W'(1);
      S_INS_MOV: idx <= idx - AW'(1);
      S_DEL_DIV: if (div_done) idx <= div_rem;
      S_DEL_MOV: idx <= idx + AW'(1);
      S_DUMP_LD: begin
        if (out_free) begin
          out_status <= ST_OK;
          out_count  <= CNT_OUT_W'(cnt);
          out_val    <= ram_rdata;
          m_tlast    <= dump_last;
          idx        <= idx + AW'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_status <= st;
          out_count  <= CNT_OUT_W'(cnt);
          out_val    <= '0;
          m_tlast    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/cpl_checker.sv -----
`include "circular_position_list_defines.svh"

module cpl_assertions #(
  parameter int DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [cpl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic [cpl_pkg::OPC_W-1:0]       s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cpl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import cpl_pkg::*;

  `CPL_ASSERT(a_out_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
    "stalled output transaction changed")
  `CPL_ASSERT_ALWAYS(a_rst_quiet, rst |=> !m_tvalid, "output valid right after reset")
  `CPL_ASSERT(a_count_bound,
    m_tvalid |-> (DEPTH > 127) || (m_tdata[8:2] <= DEPTH),
    "count above list depth")
  `CPL_ASSERT(a_empty_result,
    m_tvalid && (m_tdata[1:0] == ST_EMPTY) |->
      (m_tdata[8:2] == 7'd0) && m_tlast && (m_tdata[16:9] == 8'd0),
    "empty status with entries")
  `CPL_ASSERT(a_entry_ok,
    m_tvalid && (m_tdata[16:9] != 8'd0) |->
      (m_tdata[1:0] == ST_OK) && (m_tdata[8:2] != 7'd0),
    "entry value outside a dump")

endmodule

bind circular_position_list cpl_assertions #(.DEPTH(DEPTH)) u_checker (.*);

// ----- tb/cpl_checker.sv -----
module cpl_checker
  import cpl_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [IN_TDATA_W-1:0]         s_tdata,
  input  logic [OPC_W-1:0]              s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [OUT_TDATA_W-1:0]        m_tdata,
  input  logic                          m_tlast,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t               status;
    logic [CNT_OUT_W-1:0]  count;
    logic [VAL_W-1:0]      entry_value;
    logic                  last;
  } list_reply_t;

  // Shadow copy of the list, slot 0 is the head.
  logic [VAL_W-1:0] vertex_ring [DEPTH];
  int               vertex_count;
  list_reply_t      awaited_replies [$];
  int               error_total;

  function automatic status_t place_vertex(logic [VAL_W-1:0] v, logic [POS_W-1:0] pos);
    int slot;
    if (vertex_count >= DEPTH) return ST_FULL;
    if (vertex_count == 0) begin
      vertex_ring[0] = v;
      vertex_count = 1;
      return ST_OK;
    end
    slot = int'(pos) % vertex_count;
    for (int i = vertex_count; i > slot + 1; i--) vertex_ring[i] = vertex_ring[i-1];
    vertex_ring[slot+1] = v;
    vertex_count++;
    return ST_OK;
  endfunction

  function automatic status_t drop_vertex(logic [POS_W-1:0] pos);
    int slot;
    if (vertex_count == 0) return ST_EMPTY;
    slot = int'(pos) % vertex_count;
    for (int i = slot; i + 1 < vertex_count; i++) vertex_ring[i] = vertex_ring[i+1];
    vertex_count--;
    return ST_OK;
  endfunction

  function automatic void await_reply(status_t st, int cnt, logic [VAL_W-1:0] v, logic lst);
    list_reply_t r;
    r.status      = st;
    r.count       = CNT_OUT_W'(cnt);
    r.entry_value = v;
    r.last        = lst;
    awaited_replies.push_back(r);
  endfunction

  task automatic predict_list_op(opcode_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v,
                                 logic [NSIDE_W-1:0] nside);
    status_t st;
    st = ST_OK;
    case (op)
      OP_INSERT: st = place_vertex(v, pos);
      OP_DELETE: st = drop_vertex(pos);
      OP_POLYGON: begin
        for (int i = 2; i < int'(nside); i++) begin
          if (place_vertex(VAL_W'(1), pos) == ST_FULL) st = ST_FULL;
        end
      end
      default: begin
        if (vertex_count == 0) begin
          await_reply(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < vertex_count; i++) begin
            await_reply(ST_OK, vertex_count, vertex_ring[i], i == vertex_count - 1);
          end
        end
        return;
      end
    endcase
    await_reply(st, vertex_count, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (rst) begin
      vertex_count = 0;
      awaited_replies.delete();
      error_total = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_list_op(opcode_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], s_tdata[30:24]);
      end
      if (m_tvalid && m_tready) begin
        got.status      = status_t'(m_tdata[1:0]);
        got.count       = m_tdata[8:2];
        got.entry_value = m_tdata[16:9];
        got.last        = m_tlast;
        if (awaited_replies.size() == 0) begin
          error_total++;
          $display("%0t ns: unexpected reply, expected none,", $time,
                   " got status %0d count %0d value 0x%02h last %0d",
                   got.status, got.count, got.entry_value, got.last);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.entry_value !== want.entry_value || got.last !== want.last) begin
            error_total++;
            $display("%0t ns: reply mismatch,", $time,
                     " expected status %0d count %0d value 0x%02h last %0d,",
                     want.status, want.count, want.entry_value, want.last,
                     " got status %0d count %0d value 0x%02h last %0d",
                     got.status, got.count, got.entry_value, got.last);
          end
        end
      end
    end
    // Published with nonblocking updates so the stimulus side always reads the
    // value settled at the previous edge.
    mismatches  <= error_total;
    outstanding <= awaited_replies.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import cpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  // An insert into a nearly full list is the slowest item, since it moves almost
  // every entry, and a polygon repeats that insert for each added vertex. A normal
  // run stays well below the limit even with the heavy stall phases; the limit only catches a hang.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Long receiver hold-off, so the output register fills and the block has to
  // hold off its input.
  localparam int HOLD_CYCLES   = 800;
  // Quiet time after the last reply; every item produces at least one reply,
  // so nothing is still in flight once the last one has arrived.
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASE_ITEMS   = 75;
  localparam int MOOD_ITEMS    = 25;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_W-1:0]     s_tdata  = '0;
  logic [OPC_W-1:0]          s_tuser  = OP_INSERT;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]    m_tdata;
  logic                      m_tlast;

  int mismatches;
  int outstanding;
  int cycle_count    = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;

  always #6 clk = ~clk;

  circular_position_list #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  cpl_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offers one list operation and returns at the edge where the transaction
  // is accepted. All drives are nonblocking at the rising edge, and handshake
  // signals are read right after the edge, which gives their settled values
  // from before it. Valid is lowered only in a step where it is not raised.
  task automatic send_op(opcode_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v,
                         logic [NSIDE_W-1:0] nside);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, nside, v, pos};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until the checker has seen every reply it expects.
  // The first edge lets the checker count the transaction accepted last.
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random operation. A growing mood favors inserts and polygons so the
  // list fills up and reaches the full case; a shrinking mood favors deletes
  // so it empties again. Polygon sizes are mostly small to keep the run short,
  // a few span the whole list and a rare one uses the top of the field.
  task automatic send_random_op(bit grow);
    int pick;
    opcode_t op;
    logic [NSIDE_W-1:0] nside;
    pick = $urandom_range(99);
    if (grow) begin
      op = (pick < 45) ? OP_INSERT : (pick < 65) ? OP_DELETE :
           (pick < 77) ? OP_POLYGON : OP_DUMP;
    end else begin
      op = (pick < 15) ? OP_INSERT : (pick < 70) ? OP_DELETE :
           (pick < 75) ? OP_POLYGON : OP_DUMP;
    end
    pick = $urandom_range(39);
    if (pick == 0) begin
      nside = NSIDE_W'($urandom_range(127));
    end else if (pick < 6) begin
      nside = NSIDE_W'($urandom_range(64));
    end else begin
      nside = NSIDE_W'($urandom_range(8));
    end
    send_op(op, POS_W'($urandom_range(65535)), VAL_W'($urandom_range(255)), nside);
  endtask

  // Receiver: stalls at the rate of the current phase, or holds off for a long
  // stretch when asked, counting those cycles here on its own.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, light idling on both sides.
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    // Dump and delete on an empty list both report the empty status.
    send_op(OP_DUMP,    16'h0000, 8'h00, 7'd0);
    send_op(OP_DELETE,  16'hFFFF, 8'hFF, 7'd127);
    // First insert becomes the only entry, whatever the position.
    send_op(OP_INSERT,  16'hFFFF, 8'hFF, 7'd0);
    send_op(OP_INSERT,  16'h0000, 8'h00, 7'd127);
    send_op(OP_INSERT,  16'h8000, 8'hA5, 7'd64);
    // Polygons with fewer than three sides insert nothing.
    send_op(OP_POLYGON, 16'h0001, 8'h00, 7'd0);
    send_op(OP_POLYGON, 16'h0001, 8'hFF, 7'd2);
    send_op(OP_POLYGON, 16'h0001, 8'h3C, 7'd3);
    send_op(OP_DUMP,    16'h0000, 8'h00, 7'd0);
    send_op(OP_DELETE,  16'hFFFF, 8'h00, 7'd0);
    send_op(OP_DELETE,  16'h0000, 8'h00, 7'd0);
    // A 64-sided polygon fills the list to exactly its depth, dropping nothing.
    send_op(OP_POLYGON, 16'h0005, 8'h00, 7'd64);
    // Insert into a full list is dropped.
    send_op(OP_INSERT,  16'h0003, 8'h5A, 7'd0);
    // A dump of the full list gives the most replies one item can cause.
    send_op(OP_DUMP,    16'h7FFF, 8'h00, 7'd0);
    // Top of the side count field on a full list: every insert is dropped.
    send_op(OP_POLYGON, 16'hFFFF, 8'hFF, 7'd127);
    send_op(OP_DELETE,  16'h1234, 8'h00, 7'd0);
    send_op(OP_INSERT,  16'd63,   8'h01, 7'd0);
    send_op(OP_DELETE,  16'd63,   8'h00, 7'd0);
    send_op(OP_INSERT,  16'hAAAA, 8'h55, 7'd0);
    send_op(OP_DUMP,    16'h0000, 8'h00, 7'd0);

    // Random phases: no idling, idle sender, stalling receiver, both idle a bit.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Early in the unthrottled phase the receiver holds off for a long
        // time while the sender keeps offering, so the block backs up.
        if (ph == 0 && n == 10) hold_off_req = 1'b1;
        send_random_op(((n / MOOD_ITEMS) % 2) == (ph % 2));
      end
      // Once, the sender pauses until every outstanding reply has come back.
      if (ph == 1) drain_replies();
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
